// ----- design/kabfs_pkg.sv -----
package kabfs_pkg;

    localparam int CFG_W = 64;
    localparam int ADDR_W = 6;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_POLE = 3'd0;
    localparam logic [2:0] REG_TS   = 3'd1;
    localparam logic [2:0] REG_QA   = 3'd2;
    localparam logic [2:0] REG_QB   = 3'd3;
    localparam logic [2:0] REG_R    = 3'd4;
    localparam logic [2:0] REG_IA   = 3'd5;
    localparam logic [2:0] REG_IV   = 3'd6;
    localparam logic [2:0] REG_IP   = 3'd7;

    localparam logic [63:0] RST_POLE = 64'd4167166249;
    localparam logic [63:0] RST_TS   = 64'd41297762;
    localparam logic [63:0] RST_QA   = 64'd566544840;
    localparam logic [63:0] RST_QB   = 64'd17180;
    localparam logic [63:0] RST_R    = 64'd10737418;
    localparam logic [63:0] RST_IA   = 64'd9663676416;
    localparam logic [63:0] RST_IV   = 64'd42949673;
    localparam logic [63:0] RST_IP   = 64'd4294967;

    localparam logic CMD_FILTER  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [47:0] accel_sample;
    } t_in_beat;

    typedef struct packed {
        logic [47:0] est_accel;
        logic [47:0] est_vel;
        logic [47:0] est_pos;
        logic [47:0] est_bias;
        logic [46:0] vel_var;
        logic [46:0] pos_var;
    } t_out_beat;

endpackage

// ----- design/kabfs_if.sv -----
interface kabfs_in_if;
    import kabfs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kabfs_out_if;
    import kabfs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/kalman_accel_bias_four_state.sv -----
// One item is in work at a time: a new beat is taken only when the block is idle
// and no result is waiting.
// Throughput is set by the single shared multiplier (168 products, each with
// operand load, four 32x32 partial products, round and accumulate) and the
// 128-step bit-serial divider.
// Reset (i_rst_n, synchronous, active low) loads the register defaults, zero
// estimates and the diagonal covariance from the init registers.
module kalman_accel_bias_four_state #(
    parameter int DATA_WIDTH = 48,
    parameter int FRAC_BITS  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    kabfs_in_if.sink                  i_in,
    kabfs_out_if.source               o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kabfs_pkg::ADDR_W-1:0] paddr,
    input  logic [kabfs_pkg::CFG_W-1:0]  pwdata,
    output logic [kabfs_pkg::CFG_W-1:0]  prdata,
    output logic                      pready
);
    import kabfs_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);

    // ---------------- configuration ----------------
    logic [32:0] r_pole, r_ts;
    logic [46:0] r_qa, r_qb, r_r, r_ia, r_iv, r_ip;
    logic [2:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite && (paddr[2:0] == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole <= RST_POLE[32:0];
            r_ts   <= RST_TS[32:0];
            r_qa   <= RST_QA[46:0];
            r_qb   <= RST_QB[46:0];
            r_r    <= RST_R[46:0];
            r_ia   <= RST_IA[46:0];
            r_iv   <= RST_IV[46:0];
            r_ip   <= RST_IP[46:0];
        end else if (w_wr) begin
            case (w_idx)
                REG_POLE: r_pole <= pwdata[32:0];
                REG_TS:   r_ts   <= pwdata[32:0];
                REG_QA:   r_qa   <= pwdata[46:0];
                REG_QB:   r_qb   <= pwdata[46:0];
                REG_R:    r_r    <= pwdata[46:0];
                REG_IA:   r_ia   <= pwdata[46:0];
                REG_IV:   r_iv   <= pwdata[46:0];
                REG_IP:   r_ip   <= pwdata[46:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'd0) begin
            case (w_idx)
                REG_POLE: prdata = {31'd0, r_pole};
                REG_TS:   prdata = {31'd0, r_ts};
                REG_QA:   prdata = {17'd0, r_qa};
                REG_QB:   prdata = {17'd0, r_qb};
                REG_R:    prdata = {17'd0, r_r};
                REG_IA:   prdata = {17'd0, r_ia};
                REG_IV:   prdata = {17'd0, r_iv};
                REG_IP:   prdata = {17'd0, r_ip};
                default:  prdata = '0;
            endcase
        end
    end

    // A register value above the datapath maximum reads as that maximum.
    function automatic logic signed [DW-1:0] reg_q(input logic [46:0] v);
        logic [63:0] w;
        w = {17'd0, v};
        if (w > {{(64-DW){1'b0}}, VMAX}) reg_q = VMAX;
        else reg_q = DW'(w);
    endfunction

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) sat_add = s[DW] ? VMIN : VMAX;
        else sat_add = s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) sat_sub = s[DW] ? VMIN : VMAX;
        else sat_sub = s[DW-1:0];
    endfunction

    // ---------------- state storage ----------------
    // Work vectors: x estimates, xp predicted, h/rw/kg gain terms.
    logic signed [DW-1:0] r_x [4];
    logic signed [DW-1:0] r_xp [4];
    logic signed [DW-1:0] r_p [16];
    logic signed [DW-1:0] r_a [16];
    logic signed [DW-1:0] r_h [4];
    logic signed [DW-1:0] r_rw [4];
    logic signed [DW-1:0] r_kg [4];
    logic signed [DW-1:0] r_z, r_innov, r_inv, r_s, r_acc;

    // ---------------- shared multiplier ----------------
    // Magnitudes are split into 32-bit halves; one partial product per cycle.
    logic [63:0] r_ua, r_ub;
    logic        r_mneg;
    logic [127:0] r_prod;
    logic [1:0]  r_mph;
    logic [63:0] w_pp;
    logic [127:0] w_pp_sh;
    logic signed [DW-1:0] w_mres;

    always_comb begin
        case (r_mph)
            2'd0: begin
                w_pp    = {32'd0, r_ua[31:0]} * {32'd0, r_ub[31:0]};
                w_pp_sh = {64'd0, w_pp};
            end
            2'd1: begin
                w_pp    = {32'd0, r_ua[31:0]} * {32'd0, r_ub[63:32]};
                w_pp_sh = {32'd0, w_pp, 32'd0};
            end
            2'd2: begin
                w_pp    = {32'd0, r_ua[63:32]} * {32'd0, r_ub[31:0]};
                w_pp_sh = {32'd0, w_pp, 32'd0};
            end
            default: begin
                w_pp    = {32'd0, r_ua[63:32]} * {32'd0, r_ub[63:32]};
                w_pp_sh = {w_pp, 64'd0};
            end
        endcase
    end

    // Round magnitude, saturate, apply sign.
    always_comb begin
        logic [127:0] rnd;
        logic [127:0] lim;
        logic [127:0] mg;
        rnd = (r_prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = r_mneg ? {{(128-DW){1'b0}}, VMAX} + 128'd1 : {{(128-DW){1'b0}}, VMAX};
        mg  = (rnd > lim) ? lim : rnd;
        w_mres = r_mneg ? DW'(128'd0 - mg) : DW'(mg);
    end

    function automatic logic [63:0] mag64(input logic signed [DW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        mag64 = e[63] ? 64'(-e) : 64'(e);
    endfunction

    // ---------------- divider ----------------
    logic [63:0] r_rem;
    logic [127:0] r_quo;
    logic [6:0]  r_dcnt;

    // ---------------- sequencer ----------------
    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_MACC, ST_POST, ST_DIV, ST_DDONE, ST_OUT
    } t_state;

    // Phases of the per-sample job list.
    typedef enum logic [2:0] {
        PH_XP, PH_A, PH_PP, PH_KG, PH_X, PH_P
    } t_phase;

    t_state r_st;
    t_phase r_ph;
    logic [1:0] r_i, r_j, r_k;
    logic       r_ovalid;
    t_out_beat  r_odata;

    logic signed [DW-1:0] w_tr [4][4];
    always_comb begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) w_tr[i][j] = '0;
        w_tr[0][0] = reg_q({14'd0, r_pole});
        w_tr[1][0] = reg_q({14'd0, r_ts});
        w_tr[1][1] = ONE_Q;
        w_tr[2][1] = reg_q({14'd0, r_ts});
        w_tr[2][2] = ONE_Q;
        w_tr[3][3] = ONE_Q;
    end

    // Operand selection for the current term.
    logic signed [DW-1:0] w_opa, w_opb;
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_ph)
            PH_XP: begin w_opa = w_tr[r_i][r_k]; w_opb = r_x[r_k]; end
            PH_A:  begin w_opa = w_tr[r_i][r_k]; w_opb = r_p[{r_k, r_j}]; end
            PH_PP: begin w_opa = r_a[{r_i, r_k}]; w_opb = w_tr[r_j][r_k]; end
            PH_KG: begin w_opa = r_h[r_i]; w_opb = r_inv; end
            PH_X:  begin w_opa = r_kg[r_i]; w_opb = r_innov; end
            PH_P:  begin w_opa = r_kg[r_i]; w_opb = r_rw[r_j]; end
            default: ;
        endcase
    end

    logic w_single;
    assign w_single = (r_ph == PH_KG) || (r_ph == PH_X) || (r_ph == PH_P);

    function automatic logic [46:0] out_var(input logic signed [DW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e < 0) out_var = '0;
        else if (e > 64'sd140737488355327) out_var = '1;
        else out_var = e[46:0];
    endfunction

    function automatic logic [47:0] out_s(input logic signed [DW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'sd140737488355327) out_s = 48'h7FFF_FFFF_FFFF;
        else if (e < -64'sd140737488355328) out_s = 48'h8000_0000_0000;
        else out_s = e[47:0];
    endfunction

    assign i_in.ready   = (r_st == ST_IDLE) && !r_ovalid;
    assign o_out.valid  = r_ovalid;
    assign o_out.data   = r_odata;

    // Marks that an accepted beat is in work, so a restart's result is shown.
    logic r_ovalid_arm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid_arm <= 1'b0;
        else if (i_in.valid && i_in.ready) r_ovalid_arm <= 1'b1;
        else if (r_st == ST_OUT) r_ovalid_arm <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_LOAD;
            r_ovalid <= 1'b0;
            r_ph     <= PH_XP;
            r_i <= '0; r_j <= '0; r_k <= '0;
            r_mph    <= '0;
            r_dcnt   <= '0;
        end else begin
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        if (i_in.data.cmd == CMD_RESTART) begin
                            r_st <= ST_LOAD;
                        end else begin
                            logic signed [63:0] zs;
                            zs = 64'(signed'(i_in.data.accel_sample));
                            if (zs > 64'(VMAX)) r_z <= VMAX;
                            else if (zs < 64'(VMIN)) r_z <= VMIN;
                            else r_z <= DW'(zs);
                            r_ph <= PH_XP;
                            r_i <= '0; r_j <= '0; r_k <= '0;
                            r_acc <= '0;
                            r_st <= ST_MUL;
                        end
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 4; i++) r_x[i] <= '0;
                    for (int i = 0; i < 16; i++)
                        if ((i != 0) && (i != 5) && (i != 10) && (i != 15)) r_p[i] <= '0;
                    r_p[0]  <= reg_q(r_ia);
                    r_p[5]  <= reg_q(r_iv);
                    r_p[10] <= reg_q(r_ip);
                    r_p[15] <= reg_q(r_ia);
                    r_st <= ST_OUT;
                end
                ST_MUL: begin
                    r_ua   <= mag64(w_opa);
                    r_ub   <= mag64(w_opb);
                    r_mneg <= w_opa[DW-1] ^ w_opb[DW-1];
                    r_prod <= '0;
                    r_mph  <= '0;
                    r_st   <= ST_MACC;
                end
                ST_MACC: begin
                    r_prod <= r_prod + w_pp_sh;
                    r_mph  <= r_mph + 2'd1;
                    if (r_mph == 2'd3) r_st <= ST_POST;
                end
                ST_POST: begin
                    logic signed [DW-1:0] acc;
                    logic last;
                    t_state nx;
                    acc  = sat_add(r_acc, w_mres);
                    last = w_single || (r_k == 2'd3);
                    nx   = ST_MUL;
                    if (!last) begin
                        r_acc <= acc;
                        r_k   <= r_k + 2'd1;
                    end else begin
                        r_acc <= '0;
                        r_k   <= '0;
                        case (r_ph)
                            PH_XP: begin
                                r_xp[r_i] <= acc;
                                r_i <= r_i + 2'd1;
                                if (r_i == 2'd3) r_ph <= PH_A;
                            end
                            PH_A: begin
                                r_a[{r_i, r_j}] <= acc;
                                r_j <= r_j + 2'd1;
                                if (r_j == 2'd3) begin
                                    r_i <= r_i + 2'd1;
                                    if (r_i == 2'd3) r_ph <= PH_PP;
                                end
                            end
                            PH_PP: begin
                                // Covariance store now holds the predicted matrix.
                                r_p[{r_i, r_j}] <= acc;
                                r_j <= r_j + 2'd1;
                                if (r_j == 2'd3) begin
                                    r_i <= r_i + 2'd1;
                                    if (r_i == 2'd3) nx = ST_DIV;
                                end
                            end
                            PH_KG: begin
                                r_kg[r_i] <= w_mres;
                                r_i <= r_i + 2'd1;
                                if (r_i == 2'd3) r_ph <= PH_X;
                            end
                            PH_X: begin
                                r_x[r_i] <= sat_add(r_xp[r_i], w_mres);
                                r_i <= r_i + 2'd1;
                                if (r_i == 2'd3) r_ph <= PH_P;
                            end
                            default: begin
                                r_p[{r_i, r_j}] <= sat_sub(r_p[{r_i, r_j}], w_mres);
                                r_j <= r_j + 2'd1;
                                if (r_j == 2'd3) begin
                                    r_i <= r_i + 2'd1;
                                    if (r_i == 2'd3) nx = ST_OUT;
                                end
                            end
                        endcase
                    end
                    r_st <= nx;
                end
                ST_DIV: begin
                    // Process noise, innovation, gain terms and the divider start.
                    logic signed [DW-1:0] p00, p33, s;
                    p00 = sat_add(r_p[0], reg_q(r_qa));
                    p33 = sat_add(r_p[15], reg_q(r_qb));
                    r_p[0]  <= p00;
                    r_p[15] <= p33;
                    r_innov <= sat_sub(r_z, sat_add(r_xp[0], r_xp[3]));
                    r_h[0]  <= sat_add(p00, r_p[3]);
                    r_rw[0] <= sat_add(p00, r_p[12]);
                    r_h[3]  <= sat_add(r_p[12], p33);
                    r_rw[3] <= sat_add(r_p[3], p33);
                    for (int i = 1; i < 3; i++) begin
                        r_h[i]  <= sat_add(r_p[i*4], r_p[i*4+3]);
                        r_rw[i] <= sat_add(r_p[i], r_p[12+i]);
                    end
                    s = sat_add(sat_add(sat_add(p00, r_p[3]), sat_add(r_p[12], p33)),
                                reg_q(r_r));
                    r_s    <= s;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_dcnt <= 7'd127;
                    r_ph   <= PH_KG;
                    r_i <= '0; r_j <= '0; r_k <= '0;
                    r_st   <= ST_DDONE;
                end
                ST_DDONE: begin
                    // One restoring step per cycle over 128 quotient bits.
                    logic [64:0] rm;
                    logic [63:0] d;
                    d  = 64'(r_s);
                    rm = {r_rem, (r_dcnt == 7'(2 * FRAC_BITS))};
                    if (rm >= {1'b0, d}) begin
                        r_rem <= 64'(rm - {1'b0, d});
                        r_quo <= {r_quo[126:0], 1'b1};
                    end else begin
                        r_rem <= rm[63:0];
                        r_quo <= {r_quo[126:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd0) begin
                        logic [127:0] q;
                        q = (rm >= {1'b0, d}) ? {r_quo[126:0], 1'b1} : {r_quo[126:0], 1'b0};
                        if (r_s[DW-1] || (r_s == '0)) r_inv <= '0;
                        else if (q > {{(128-DW){1'b0}}, VMAX}) r_inv <= VMAX;
                        else r_inv <= DW'(q);
                        r_st <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    r_odata.est_accel <= out_s(r_x[0]);
                    r_odata.est_vel   <= out_s(r_x[1]);
                    r_odata.est_pos   <= out_s(r_x[2]);
                    r_odata.est_bias  <= out_s(r_x[3]);
                    r_odata.vel_var   <= out_var(r_p[5]);
                    r_odata.pos_var   <= out_var(r_p[10]);
                    // Reset also passes through here; its beat is not shown.
                    r_ovalid <= (r_ph != PH_XP) || r_ovalid_arm;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/kabfs_checker.sv -----
module kabfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [47:0] out_vel,
    input logic pready
);
    // A waiting result beat holds its valid and its velocity field.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_vel))
        else $error("result beat changed while stalled");

    // No new item is taken while a result is still waiting.
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted with result pending");

    // The block goes busy after an accepted item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind kalman_accel_bias_four_state kabfs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_vel(o_out.data.est_vel), .pready(pready)
);
